### hdl/sam_pkg.sv
`default_nettype none
package sam_pkg;
    localparam int MaxText    = 4096;
    localparam int Alphabet   = 26;
    localparam int MaxStates  = 2 * MaxText;
    localparam int StW        = $clog2(MaxStates);
    localparam int LenW       = $clog2(MaxText + 1);
    localparam int SymW       = 5;
    localparam int TrDepth    = MaxStates * Alphabet;
    localparam int TrAw       = $clog2(TrDepth);

    typedef logic [StW-1:0]  t_state;
    typedef logic [LenW-1:0] t_len;
    typedef logic [SymW-1:0] t_sym;
    typedef logic [TrAw-1:0] t_tr_addr;

    localparam logic [1:0] ActClear   = 2'd0;
    localparam logic [1:0] ActExtend  = 2'd1;
    localparam logic [1:0] ActMatch   = 2'd2;
    localparam logic [1:0] ActRestart = 2'd3;

    localparam t_state Root = '0;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR_ROOT,
        S_EXT_NEWROW,
        S_EXT_RDP,
        S_EXT_CHKP,
        S_EXT_RDQ,
        S_EXT_CHKQ,
        S_CPY_RD,
        S_CPY_WR,
        S_RED_RD,
        S_RED_CHK,
        S_MAT_RD,
        S_MAT_CHK,
        S_OUT
    } t_fsm;

    // memory request bundle from sequencer to state store
    typedef struct packed {
        logic     tr_we;
        t_tr_addr tr_waddr;
        t_state   tr_wdata;
        t_tr_addr tr_raddr;
        logic     lk_we;
        t_state   lk_waddr;
        t_state   lk_wdata;
        t_state   lk_raddr;
        logic     ln_we;
        t_state   ln_waddr;
        t_len     ln_wdata;
        t_state   ln_raddr;
    } t_mem_req;

    typedef struct packed {
        t_state tr_rdata;
        t_state lk_rdata;
        t_len   ln_rdata;
    } t_mem_rsp;

    function automatic t_tr_addr tr_addr(t_state st, t_sym sym);
        logic [TrAw+SymW-1:0] a;
        a = TrAw'(st) * TrAw'(Alphabet) + TrAw'(sym);
        return a[TrAw-1:0];
    endfunction
endpackage
`default_nettype wire

### hdl/sam_store.sv
`default_nettype none
module sam_store (
    input  wire logic              i_clk,
    input  wire sam_pkg::t_mem_req i_req,
    output sam_pkg::t_mem_rsp      o_rsp
);
    sam_pkg::t_state r_tr [sam_pkg::TrDepth];
    sam_pkg::t_state r_lk [sam_pkg::MaxStates];
    sam_pkg::t_len   r_ln [sam_pkg::MaxStates];

    // read-first synchronous memories
    always_ff @(posedge i_clk) begin
        if (i_req.tr_we) r_tr[i_req.tr_waddr] <= i_req.tr_wdata;
        if (i_req.lk_we) r_lk[i_req.lk_waddr] <= i_req.lk_wdata;
        if (i_req.ln_we) r_ln[i_req.ln_waddr] <= i_req.ln_wdata;
        o_rsp.tr_rdata <= r_tr[i_req.tr_raddr];
        o_rsp.lk_rdata <= r_lk[i_req.lk_raddr];
        o_rsp.ln_rdata <= r_ln[i_req.ln_raddr];
    end
endmodule
`default_nettype wire

### hdl/sam_seq.sv
`default_nettype none
module sam_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_action,
    input  wire sam_pkg::t_sym     i_symbol,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output sam_pkg::t_len          o_match_len,
    output sam_pkg::t_state        o_state_index,
    output logic                   o_status,
    output sam_pkg::t_mem_req      o_req,
    input  wire sam_pkg::t_mem_rsp i_rsp
);
    sam_pkg::t_fsm   r_fsm, n_fsm;
    sam_pkg::t_state r_last, n_last, r_used, n_used, r_mst, n_mst;
    sam_pkg::t_len   r_tlen, n_tlen, r_mlen, n_mlen;
    sam_pkg::t_sym   r_sym, n_sym;
    sam_pkg::t_state r_p, n_p, r_np, n_np, r_q, n_q, r_nq, n_nq;
    sam_pkg::t_len   r_lp, n_lp;
    logic [sam_pkg::SymW-1:0] r_cnt, n_cnt;
    logic            r_clone, n_clone; // set once np's length has been written
    logic            r_ov, n_ov;
    sam_pkg::t_len   r_olen, n_olen;
    sam_pkg::t_state r_ost, n_ost;
    logic            r_ost_s, n_ost_s;
    sam_pkg::t_len   r_dlen, n_dlen;   // output register
    sam_pkg::t_state r_dst, n_dst;
    logic            r_ds, n_ds;
    logic            acc;
    logic [sam_pkg::StW:0] used_p2;

    assign acc = i_valid && !o_stall;
    assign o_stall = (r_fsm != sam_pkg::S_IDLE);
    assign o_valid = r_ov;
    assign o_match_len = r_dlen;
    assign o_state_index = r_dst;
    assign o_status = r_ds;
    assign used_p2 = {1'b0, r_used} + (sam_pkg::StW+1)'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= sam_pkg::S_CLR_ROOT;
            r_last <= sam_pkg::Root; r_used <= sam_pkg::StW'(1);
            r_tlen <= '0; r_mst <= sam_pkg::Root; r_mlen <= '0;
            r_ov <= 1'b0; r_cnt <= '0;
        end else begin
            r_fsm <= n_fsm; r_last <= n_last; r_used <= n_used;
            r_tlen <= n_tlen; r_mst <= n_mst; r_mlen <= n_mlen;
            r_ov <= n_ov; r_cnt <= n_cnt;
        end
    end
    always_ff @(posedge i_clk) begin
        r_sym <= n_sym; r_p <= n_p; r_np <= n_np; r_q <= n_q; r_nq <= n_nq;
        r_lp <= n_lp; r_clone <= n_clone;
        r_olen <= n_olen; r_ost <= n_ost; r_ost_s <= n_ost_s;
        r_dlen <= n_dlen; r_dst <= n_dst; r_ds <= n_ds;
    end

    always_comb begin
        n_fsm = r_fsm; n_last = r_last; n_used = r_used; n_tlen = r_tlen;
        n_mst = r_mst; n_mlen = r_mlen; n_sym = r_sym; n_p = r_p; n_np = r_np;
        n_q = r_q; n_nq = r_nq; n_lp = r_lp; n_cnt = r_cnt; n_clone = r_clone;
        n_ov = r_ov; n_olen = r_olen; n_ost = r_ost; n_ost_s = r_ost_s;
        n_dlen = r_dlen; n_dst = r_dst; n_ds = r_ds;
        o_req = '0;
        if (r_ov && !i_stall) n_ov = 1'b0;
        unique case (r_fsm)
            sam_pkg::S_IDLE: begin
                if (acc) begin
                    n_sym = i_symbol;
                    n_ost_s = 1'b0;
                    unique case (i_action)
                        sam_pkg::ActClear: begin
                            n_last = sam_pkg::Root; n_used = sam_pkg::StW'(1);
                            n_tlen = '0; n_mst = sam_pkg::Root; n_mlen = '0;
                            n_cnt = '0; n_fsm = sam_pkg::S_CLR_ROOT;
                            n_olen = '0; n_ost = sam_pkg::Root;
                        end
                        sam_pkg::ActExtend: begin
                            if (32'(i_symbol) >= sam_pkg::Alphabet ||
                                32'(r_tlen) >= sam_pkg::MaxText ||
                                32'(used_p2) > sam_pkg::MaxStates) begin
                                n_ost_s = 1'b1; n_olen = r_tlen; n_ost = r_last;
                                n_fsm = sam_pkg::S_OUT;
                            end else begin
                                n_p = r_last; n_np = r_used;
                                n_used = r_used + sam_pkg::StW'(1);
                                n_cnt = '0; n_clone = 1'b0;
                                n_fsm = sam_pkg::S_EXT_NEWROW;
                            end
                        end
                        sam_pkg::ActMatch: begin
                            if (32'(i_symbol) >= sam_pkg::Alphabet) begin
                                n_ost_s = 1'b1; n_olen = r_mlen; n_ost = r_mst;
                                n_fsm = sam_pkg::S_OUT;
                            end else begin
                                n_p = r_mst; n_fsm = sam_pkg::S_MAT_RD;
                            end
                        end
                        default: begin
                            n_mst = sam_pkg::Root; n_mlen = '0;
                            n_olen = '0; n_ost = sam_pkg::Root;
                            n_fsm = sam_pkg::S_OUT;
                        end
                    endcase
                end
            end
            sam_pkg::S_CLR_ROOT: begin
                // clear the root row, and with it its length and link
                o_req.tr_we = 1'b1;
                o_req.tr_waddr = sam_pkg::tr_addr(sam_pkg::Root, r_cnt);
                o_req.tr_wdata = sam_pkg::Root;
                o_req.ln_we = 1'b1; o_req.ln_waddr = sam_pkg::Root;
                o_req.lk_we = 1'b1; o_req.lk_waddr = sam_pkg::Root;
                n_cnt = r_cnt + sam_pkg::SymW'(1);
                if (32'(r_cnt) == sam_pkg::Alphabet - 1) begin
                    n_cnt = '0; n_fsm = sam_pkg::S_OUT;
                end
            end
            sam_pkg::S_EXT_NEWROW: begin
                o_req.tr_we = 1'b1;
                o_req.tr_waddr = sam_pkg::tr_addr(r_np, r_cnt);
                o_req.tr_wdata = sam_pkg::Root;
                o_req.ln_raddr = r_p;
                n_cnt = r_cnt + sam_pkg::SymW'(1);
                if (32'(r_cnt) == sam_pkg::Alphabet - 1) begin
                    n_cnt = '0; n_fsm = sam_pkg::S_EXT_RDP;
                end
            end
            sam_pkg::S_EXT_RDP: begin
                if (r_cnt == '0 && !r_clone) begin
                    // length of last state arrives now
                    o_req.ln_we = 1'b1; o_req.ln_waddr = r_np;
                    o_req.ln_wdata = i_rsp.ln_rdata + sam_pkg::LenW'(1);
                    n_clone = 1'b1;
                end
                o_req.tr_raddr = sam_pkg::tr_addr(r_p, r_sym);
                o_req.lk_raddr = r_p; o_req.ln_raddr = r_p;
                n_fsm = sam_pkg::S_EXT_CHKP;
            end
            sam_pkg::S_EXT_CHKP: begin
                if (i_rsp.tr_rdata == sam_pkg::Root) begin
                    o_req.tr_we = 1'b1;
                    o_req.tr_waddr = sam_pkg::tr_addr(r_p, r_sym);
                    o_req.tr_wdata = r_np;
                    if (r_p == sam_pkg::Root) begin
                        o_req.lk_we = 1'b1; o_req.lk_waddr = r_np;
                        o_req.lk_wdata = sam_pkg::Root;
                        n_fsm = sam_pkg::S_OUT;
                    end else begin
                        n_p = i_rsp.lk_rdata; n_fsm = sam_pkg::S_EXT_RDP;
                    end
                end else begin
                    n_q = i_rsp.tr_rdata; n_lp = i_rsp.ln_rdata;
                    n_fsm = sam_pkg::S_EXT_RDQ;
                end
                if (n_fsm == sam_pkg::S_OUT) begin
                    n_last = r_np; n_tlen = r_tlen + sam_pkg::LenW'(1);
                    n_olen = r_tlen + sam_pkg::LenW'(1); n_ost = r_np;
                end
            end
            sam_pkg::S_EXT_RDQ: begin
                o_req.ln_raddr = r_q; o_req.lk_raddr = r_q;
                n_fsm = sam_pkg::S_EXT_CHKQ;
            end
            sam_pkg::S_EXT_CHKQ: begin
                if (r_lp + sam_pkg::LenW'(1) == i_rsp.ln_rdata) begin
                    o_req.lk_we = 1'b1; o_req.lk_waddr = r_np;
                    o_req.lk_wdata = r_q;
                    n_last = r_np; n_tlen = r_tlen + sam_pkg::LenW'(1);
                    n_olen = r_tlen + sam_pkg::LenW'(1); n_ost = r_np;
                    n_fsm = sam_pkg::S_OUT;
                end else begin
                    // clone: nq takes q's link, length lp+1
                    n_nq = r_used; n_used = r_used + sam_pkg::StW'(1);
                    o_req.lk_we = 1'b1; o_req.lk_waddr = r_used;
                    o_req.lk_wdata = i_rsp.lk_rdata;
                    o_req.ln_we = 1'b1; o_req.ln_waddr = r_used;
                    o_req.ln_wdata = r_lp + sam_pkg::LenW'(1);
                    n_cnt = '0; n_fsm = sam_pkg::S_CPY_RD;
                end
            end
            sam_pkg::S_CPY_RD: begin
                o_req.tr_raddr = sam_pkg::tr_addr(r_q, r_cnt);
                if (r_cnt == '0) begin
                    o_req.lk_we = 1'b1; o_req.lk_waddr = r_q;
                    o_req.lk_wdata = r_nq;
                end else if (r_cnt == sam_pkg::SymW'(1)) begin
                    o_req.lk_we = 1'b1; o_req.lk_waddr = r_np;
                    o_req.lk_wdata = r_nq;
                end
                n_fsm = sam_pkg::S_CPY_WR;
            end
            sam_pkg::S_CPY_WR: begin
                o_req.tr_we = 1'b1;
                o_req.tr_waddr = sam_pkg::tr_addr(r_nq, r_cnt);
                o_req.tr_wdata = i_rsp.tr_rdata;
                n_cnt = r_cnt + sam_pkg::SymW'(1);
                n_fsm = sam_pkg::S_CPY_RD;
                if (32'(r_cnt) == sam_pkg::Alphabet - 1) begin
                    n_cnt = '0; n_fsm = sam_pkg::S_RED_RD;
                end
            end
            sam_pkg::S_RED_RD: begin
                o_req.tr_raddr = sam_pkg::tr_addr(r_p, r_sym);
                o_req.lk_raddr = r_p;
                n_fsm = sam_pkg::S_RED_CHK;
            end
            sam_pkg::S_RED_CHK: begin
                if (i_rsp.tr_rdata == r_q) begin
                    o_req.tr_we = 1'b1;
                    o_req.tr_waddr = sam_pkg::tr_addr(r_p, r_sym);
                    o_req.tr_wdata = r_nq;
                end
                if (i_rsp.tr_rdata == r_q && r_p != sam_pkg::Root) begin
                    n_p = i_rsp.lk_rdata; n_fsm = sam_pkg::S_RED_RD;
                end else begin
                    n_last = r_np; n_tlen = r_tlen + sam_pkg::LenW'(1);
                    n_olen = r_tlen + sam_pkg::LenW'(1); n_ost = r_np;
                    n_fsm = sam_pkg::S_OUT;
                end
            end
            sam_pkg::S_MAT_RD: begin
                o_req.tr_raddr = sam_pkg::tr_addr(r_p, r_sym);
                o_req.lk_raddr = r_p; o_req.ln_raddr = r_p;
                n_fsm = sam_pkg::S_MAT_CHK;
            end
            sam_pkg::S_MAT_CHK: begin
                if (i_rsp.tr_rdata != sam_pkg::Root) begin
                    if (r_p == r_mst) begin
                        if (32'(r_mlen) < sam_pkg::MaxText)
                            n_mlen = r_mlen + sam_pkg::LenW'(1);
                    end else if (32'(i_rsp.ln_rdata) + 1 > sam_pkg::MaxText) begin
                        n_mlen = sam_pkg::LenW'(sam_pkg::MaxText);
                    end else begin
                        n_mlen = i_rsp.ln_rdata + sam_pkg::LenW'(1);
                    end
                    n_mst = i_rsp.tr_rdata;
                    n_fsm = sam_pkg::S_OUT;
                end else if (r_p == sam_pkg::Root) begin
                    n_mst = sam_pkg::Root; n_mlen = '0; n_fsm = sam_pkg::S_OUT;
                end else begin
                    n_p = i_rsp.lk_rdata; n_fsm = sam_pkg::S_MAT_RD;
                end
                n_olen = n_mlen; n_ost = n_mst;
            end
            sam_pkg::S_OUT: begin
                // load the output register once it is free or draining
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_dlen = r_olen; n_dst = r_ost; n_ds = r_ost_s;
                    n_fsm = sam_pkg::S_IDLE;
                end
            end
            default: n_fsm = sam_pkg::S_IDLE;
        endcase
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov && $stable(r_dlen) && $stable(r_dst) && $stable(r_ds))
        else $error("output word changed under stall");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm != sam_pkg::S_IDLE |-> o_stall)
        else $error("input taken while busy");
    a_used_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= sam_pkg::MaxStates)
        else $error("state count overflow");
endmodule
`default_nettype wire

### hdl/suffix_automaton_build_match.sv
`default_nettype none
// channel | valid   | stall   | word
// in      | i_valid | o_stall | i_action, i_symbol
// out     | o_valid | i_stall | o_match_len, o_state_index, o_status
//
// one item at a time; a match does a read and a check per suffix-link step
// extend clears the new state's row, does a read and a check per link step
// and for q, and for a clone copies q's row and does a read and a check per
// redirect step; clear wipes the root row one entry a cycle; reset runs the
// same wipe, during which input is stalled and no word is sent
// input is stalled while an item is in work or its word waits for the
// output register; a word held there does not block the next item
module suffix_automaton_build_match (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [1:0]            i_action,
    input  wire logic [4:0]            i_symbol,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [12:0]                o_match_len,
    output logic [13:0]                o_state_index,
    output logic                       o_status
);
    sam_pkg::t_mem_req req;
    sam_pkg::t_mem_rsp rsp;
    sam_pkg::t_state   seq_state;
    logic r_boot;
    logic seq_valid;

    // first pass after reset is the root wipe; its word is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_boot <= 1'b1;
        else if (seq_valid) r_boot <= 1'b0;
    end
    assign o_valid = seq_valid && !r_boot;
    assign o_state_index = 14'(seq_state);

    sam_seq u_seq (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_action,
        .i_symbol(i_symbol),
        .o_valid(seq_valid),
        .i_stall(i_stall && !r_boot),
        .o_match_len,
        .o_state_index(seq_state),
        .o_status,
        .o_req(req), .i_rsp(rsp)
    );
    sam_store u_store (.i_clk, .i_req(req), .o_rsp(rsp));
endmodule
`default_nettype wire

### dv/suffix_automaton_build_match_tb.sv
`timescale 1ns / 100ps

// expected word for one accepted item
typedef struct {
    logic [12:0] len;
    logic [13:0] st;
    logic        status;
} t_sam_word;

// scoreboard: shadow suffix automaton plus queue of expected words
class sam_scoreboard;
    int unsigned   trans[];
    int unsigned   link[];
    int unsigned   slen[];
    int unsigned   last_st, used, text_len, m_st, m_len;
    t_sam_word     pending[$];
    int            errors;

    function new();
        trans = new[sam_pkg::MaxStates * sam_pkg::Alphabet];
        link  = new[sam_pkg::MaxStates];
        slen  = new[sam_pkg::MaxStates];
        errors = 0;
        wipe();
    endfunction

    function void clear_row(int unsigned s);
        for (int k = 0; k < sam_pkg::Alphabet; k++) trans[s * sam_pkg::Alphabet + k] = 0;
    endfunction

    function void wipe();
        clear_row(0);
        link[0] = 0;
        slen[0] = 0;
        last_st = 0;
        used = 1;
        text_len = 0;
        m_st = 0;
        m_len = 0;
    endfunction

    function void append(int unsigned w);
        int unsigned p, np, q, nq, a;
        bit live;
        a = sam_pkg::Alphabet;
        p = last_st;
        np = used;
        used++;
        live = 1;
        clear_row(np);
        slen[np] = slen[p] + 1;
        while (live && trans[p * a + w] == 0) begin
            trans[p * a + w] = np;
            if (p == 0) live = 0; else p = link[p];
        end
        if (!live) begin
            link[np] = 0;
        end else begin
            q = trans[p * a + w];
            if (slen[p] + 1 == slen[q]) begin
                link[np] = q;
            end else begin
                nq = used;
                used++;
                for (int k = 0; k < a; k++)
                    trans[nq * a + k] = trans[q * a + k];
                slen[nq] = slen[p] + 1;
                link[nq] = link[q];
                link[q] = nq;
                link[np] = nq;
                while (live && trans[p * a + w] == q) begin
                    trans[p * a + w] = nq;
                    if (p == 0) live = 0; else p = link[p];
                end
            end
        end
        last_st = np;
        text_len++;
    endfunction

    function void follow(int unsigned w);
        int unsigned nxt, p, a;
        a = sam_pkg::Alphabet;
        nxt = trans[m_st * a + w];
        if (nxt != 0) begin
            if (m_len < sam_pkg::MaxText) m_len++;
            m_st = nxt;
            return;
        end
        p = m_st;
        while (p != 0 && trans[p * a + w] == 0) p = link[p];
        nxt = trans[p * a + w];
        if (nxt != 0) begin
            m_len = slen[p] + 1;
            if (m_len > sam_pkg::MaxText) m_len = sam_pkg::MaxText;
            m_st = nxt;
        end else begin
            m_len = 0;
            m_st = 0;
        end
    endfunction

    // an accepted input word: advance the shadow and queue its result
    function void note_input(logic [1:0] act, logic [4:0] sym);
        t_sam_word e;
        e.len = '0;
        e.st = '0;
        e.status = 1'b0;
        case (act)
            sam_pkg::ActClear: begin
                wipe();
            end
            sam_pkg::ActExtend: begin
                if (sym >= sam_pkg::Alphabet || text_len >= sam_pkg::MaxText ||
                    used + 2 > sam_pkg::MaxStates)
                    e.status = 1'b1;
                else
                    append(sym);
                e.len = text_len[12:0];
                e.st = last_st[13:0];
            end
            sam_pkg::ActMatch: begin
                if (sym >= sam_pkg::Alphabet) e.status = 1'b1;
                else follow(sym);
                e.len = m_len[12:0];
                e.st = m_st[13:0];
            end
            default: begin
                m_st = 0;
                m_len = 0;
            end
        endcase
        pending.push_back(e);
    endfunction

    function void check_output(logic [12:0] len, logic [13:0] st, logic status);
        t_sam_word e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word len=%0d st=%0d status=%0d",
                     $realtime, len, st, status);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (len !== e.len) begin
            $display("%0t: match_len exp %0d got %0d", $realtime, e.len, len);
            errors++;
        end
        if (st !== e.st) begin
            $display("%0t: state_index exp %0d got %0d", $realtime, e.st, st);
            errors++;
        end
        if (status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $realtime, e.status, status);
            errors++;
        end
    endfunction
endclass

module suffix_automaton_build_match_tb;
    localparam int IdleLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_action = sam_pkg::ActClear;
    logic [4:0]  i_symbol = '0;
    logic        i_stall = 1'b0;
    logic        o_stall, o_valid, o_status;
    logic [12:0] o_match_len;
    logic [13:0] o_state_index;

    sam_scoreboard board = new();
    bit          hold_off = 0;   // long receiver hold-off requested
    int          idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    suffix_automaton_build_match uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_symbol(i_symbol),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_match_len(o_match_len), .o_state_index(o_state_index),
        .o_status(o_status)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one word and hold it until taken; gap first
    task automatic send_word(logic [1:0] act, logic [4:0] sym, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_symbol <= sym;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_input(act, sym);
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // text over a small alphabet subset so that repeats and clones show up
    function automatic logic [4:0] text_sym(int span);
        return 5'($urandom_range(0, span - 1));
    endfunction

    // output side: sample at rising edge, random stalls driven at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_output(o_match_len, o_state_index, o_status);
    end

    initial begin : rx_stall
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
                i_stall <= 1'b0;
                hold_off = 0;
            end else begin
                g = gap_len();
                i_stall <= (g > 0 && $urandom_range(0, 2) == 0);
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int n, span, kind, tries;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty-automaton matches, extremes, out of alphabet
        send_word(sam_pkg::ActMatch, 5'd0, 0);
        send_word(sam_pkg::ActMatch, 5'd25, 0);
        send_word(sam_pkg::ActMatch, 5'd31, 0);
        send_word(sam_pkg::ActExtend, 5'd26, 0);
        send_word(sam_pkg::ActExtend, 5'd31, 0);
        // "abbbaz": the second "b" forces a clone
        send_word(sam_pkg::ActExtend, 5'd0, 0);
        send_word(sam_pkg::ActExtend, 5'd1, 0);
        send_word(sam_pkg::ActExtend, 5'd1, 0);
        send_word(sam_pkg::ActExtend, 5'd1, 0);
        send_word(sam_pkg::ActExtend, 5'd0, 0);
        send_word(sam_pkg::ActExtend, 5'd25, 0);
        send_word(sam_pkg::ActMatch, 5'd1, 0);
        send_word(sam_pkg::ActMatch, 5'd1, 0);
        send_word(sam_pkg::ActMatch, 5'd1, 0);
        send_word(sam_pkg::ActMatch, 5'd1, 0);
        send_word(sam_pkg::ActMatch, 5'd0, 0);
        send_word(sam_pkg::ActMatch, 5'd24, 0);
        send_word(sam_pkg::ActMatch, 5'd30, 0);
        send_word(sam_pkg::ActRestart, 5'd31, 0);
        send_word(sam_pkg::ActMatch, 5'd25, 0);
        send_word(sam_pkg::ActClear, 5'd31, 0);
        send_word(sam_pkg::ActMatch, 5'd0, 0);
        send_word(sam_pkg::ActRestart, 5'd0, 0);

        // pressure: receiver holds off while words keep coming
        hold_off = 1;
        for (int k = 0; k < 12; k++) send_word(sam_pkg::ActExtend, text_sym(3), 0);

        // random: sessions of build text then match against it
        n = 0;
        while (n < 1400) begin
            span = ($urandom_range(0, 3) == 0) ? 26 : $urandom_range(2, 4);
            send_word(sam_pkg::ActClear, 5'($urandom), 1);
            n++;
            tries = $urandom_range(5, 60);
            for (int k = 0; k < tries; k++) begin
                kind = $urandom_range(0, 19);
                if (kind == 0)
                    send_word(sam_pkg::ActExtend, 5'($urandom_range(26, 31)), 1);
                else if (kind == 1) send_word(sam_pkg::ActMatch, text_sym(span), 1);
                else send_word(sam_pkg::ActExtend, text_sym(span), 1);
                n++;
            end
            tries = $urandom_range(5, 40);
            for (int k = 0; k < tries; k++) begin
                kind = $urandom_range(0, 19);
                if (kind == 0) send_word(sam_pkg::ActRestart, 5'($urandom), 1);
                else if (kind == 1)
                    send_word(sam_pkg::ActMatch, 5'($urandom_range(26, 31)), 1);
                else if (kind == 2) send_word(sam_pkg::ActExtend, text_sym(span), 1);
                else send_word(sam_pkg::ActMatch, text_sym(span), 1);
                n++;
            end
        end

        // long text of mostly one letter, then matches against it
        send_word(sam_pkg::ActClear, 5'd0, 0);
        for (int k = 0; k < 100; k++)
            send_word(sam_pkg::ActExtend, ($urandom_range(0, 7) == 0) ? 5'd25 : 5'd0, 0);
        for (int k = 0; k < 40; k++) send_word(sam_pkg::ActMatch, text_sym(2), 1);
        send_word(sam_pkg::ActMatch, 5'd25, 0);
        go_idle();

        // drain, then a short settle
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
